// ----- rtl/dtcp_pkg.sv -----
// Shared types, constants and the month-length function for the
// date-time command parser. No dependencies.
package dtcp_pkg;

  localparam int CMD_LEN  = 16;
  localparam int POS_W    = 5;
  localparam int POS_MAX  = 31;
  localparam int CHAR_W   = 8;
  localparam int TDATA_W  = 40;

  localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;
  localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
  localparam int DIGIT_ZERO = 48;

  localparam int YEAR_MAX   = 9999;
  localparam int MONTH_MAX  = 12;
  localparam int HOUR_MAX   = 23;
  localparam int MINSEC_MAX = 59;

  // floor(y / 25) for y < 2**14 as (y * RECIP25) >> RECIP25_SHIFT
  localparam logic [14:0] RECIP25       = 15'd20972;
  localparam int          RECIP25_SHIFT = 19;

  // Values accumulated so far, as signed sums of (byte - '0') digits.
  typedef struct packed {
    logic signed [19:0] year;
    logic signed [12:0] month;
    logic signed [12:0] day;
    logic signed [12:0] hour;
    logic signed [12:0] minute;
    logic signed [12:0] second;
  } dtcp_fields_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
      4'd2:                                      d = leap ? 5'd29 : 5'd28;
      default:                                   d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/dtcp_range_check.sv -----
// Format and range check of a completed date-time command.
// Depends on dtcp_pkg.
module dtcp_range_check import dtcp_pkg::*; (
  input  dtcp_fields_t     fields,
  input  logic [POS_W-1:0] pos_next,
  input  logic             header_ok,
  input  logic             leap,
  output logic             ok
);

  logic [4:0]         max_day;
  logic signed [12:0] max_day_s;

  assign max_day   = month_days(fields.month[3:0], leap);
  assign max_day_s = $signed({8'd0, max_day});

  always_comb begin
    ok = (pos_next == POS_W'(CMD_LEN)) && header_ok
      && (fields.year   >= 20'sd0) && (fields.year   <= 20'(YEAR_MAX))
      && (fields.month  >= 13'sd1) && (fields.month  <= 13'(MONTH_MAX))
      && (fields.day    >= 13'sd1) && (fields.day    <= max_day_s)
      && (fields.hour   >= 13'sd0) && (fields.hour   <= 13'(HOUR_MAX))
      && (fields.minute >= 13'sd0) && (fields.minute <= 13'(MINSEC_MAX))
      && (fields.second >= 13'sd0) && (fields.second <= 13'(MINSEC_MAX));
  end

endmodule

// ----- rtl/datetime_command_parser.sv -----
// Top level of the date-time set command parser: input register, digit
// accumulators, leap-year pipeline and result register.
// Depends on dtcp_pkg and dtcp_range_check.
//
// Usage: a command such as "TA20240229123000" arrives one byte per request
// on the slave stream (s_tdata = character, s_tlast set on the final one).
// Every character lands in an input register and is folded into the
// accumulators when it leaves it; a request with s_tlast set also loads the
// result register, which presents one result on the master stream.
// m_tuser is the valid flag; m_tdata carries year, month, day, hour,
// minute and second, all zero when any length, header or range check fails.
// After the final character all parser state returns to its reset value.
//
// m_tvalid rises when the final character leaves the input register for
// the result register. One character is taken every cycle while s_tready
// is high; the output register lets the next command stream in while a
// result waits. Only a final character has to wait for the result register,
// so a stalled receiver holds back the input only once a second final
// character reaches the input register. The leap-year flag is derived from
// the year over two registered stages, which the ten characters between the
// year and the end of a command cover. Synchronous active-high reset
// empties both registers and clears the accumulators.
module datetime_command_parser import dtcp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] char_code
  input  logic               s_tlast,   // last_char
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [13:0] year, [17:14] month, [22:18] day,
                                        // [27:23] hour, [33:28] minute, [39:34] second
  output logic               m_tuser    // valid_res
);

  // Input register.
  logic              a_valid;
  logic [CHAR_W-1:0] a_char;
  logic              a_last;
  logic              a_move;

  // Parser state.
  logic [POS_W-1:0]   pos;
  logic               header_ok;
  logic signed [19:0] year_sum;
  logic signed [12:0] month_sum, day_sum, hour_sum, minute_sum, second_sum;

  logic [POS_W-1:0]   pos_next;
  logic               header_ok_next;
  dtcp_fields_t       fields_next;
  logic signed [8:0]  digit;
  logic signed [19:0] year_acc, month_acc, day_acc, hour_acc, minute_acc, second_acc;

  // Leap-year pipeline.
  logic [28:0] year_prod;
  logic [9:0]  year_quot;
  logic [13:0] year_q25;
  logic        year_leap;
  logic        year_div25;

  logic                 cmd_ok;
  logic [TDATA_W-1:0]   result_data;

  function automatic logic signed [19:0] acc10(input logic signed [19:0] s,
                                               input logic signed [8:0]  d);
    logic signed [23:0] w;
    w = 24'(s) * 24'sd10 + 24'(d);
    return w[19:0];
  endfunction

  // A final character may only leave when the result register is free.
  assign a_move   = a_valid && (!a_last || !m_tvalid || m_tready);
  assign s_tready = !a_valid || a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      a_char <= s_tdata;
      a_last <= s_tlast;
    end
  end

  // Each character counts as its byte value minus the code of zero.
  assign digit = $signed({1'b0, a_char}) - 9'sd48;

  assign year_acc   = acc10(year_sum, digit);
  assign month_acc  = acc10(20'(month_sum), digit);
  assign day_acc    = acc10(20'(day_sum), digit);
  assign hour_acc   = acc10(20'(hour_sum), digit);
  assign minute_acc = acc10(20'(minute_sum), digit);
  assign second_acc = acc10(20'(second_sum), digit);

  always_comb begin
    pos_next       = (pos < POS_W'(POS_MAX)) ? pos + 1'b1 : pos;
    header_ok_next = header_ok;
    fields_next    = '{year: year_sum, month: month_sum, day: day_sum,
                       hour: hour_sum, minute: minute_sum, second: second_sum};
    unique case (pos) inside
      5'd0:           if (a_char != CHAR_T_UP && a_char != CHAR_T_LO) header_ok_next = 1'b0;
      5'd1:           if (a_char != CHAR_A_UP && a_char != CHAR_A_LO) header_ok_next = 1'b0;
      [5'd2:5'd5]:    fields_next.year   = year_acc;
      [5'd6:5'd7]:    fields_next.month  = month_acc[12:0];
      [5'd8:5'd9]:    fields_next.day    = day_acc[12:0];
      [5'd10:5'd11]:  fields_next.hour   = hour_acc[12:0];
      [5'd12:5'd13]:  fields_next.minute = minute_acc[12:0];
      [5'd14:5'd15]:  fields_next.second = second_acc[12:0];
      default:        ;  // characters past the sixteenth are only counted
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (a_move && a_last)) begin
      pos        <= '0;
      header_ok  <= 1'b1;
      year_sum   <= '0;
      month_sum  <= '0;
      day_sum    <= '0;
      hour_sum   <= '0;
      minute_sum <= '0;
      second_sum <= '0;
    end else if (a_move) begin
      pos        <= pos_next;
      header_ok  <= header_ok_next;
      year_sum   <= fields_next.year;
      month_sum  <= fields_next.month;
      day_sum    <= fields_next.day;
      hour_sum   <= fields_next.hour;
      minute_sum <= fields_next.minute;
      second_sum <= fields_next.second;
    end
  end

  // Leap year: divisible by 4 but not 100, or by 400. With d25 meaning
  // divisible by 25, that is (y % 4 == 0 && !d25) || (y % 16 == 0 && d25).
  // Only years 0..9999 matter, so the low 14 bits suffice.
  assign year_prod  = 29'(year_sum[13:0] * RECIP25);
  assign year_q25   = 14'({year_quot, 4'b0}) + 14'({year_quot, 3'b0}) + 14'(year_quot);
  assign year_div25 = (year_q25 == year_sum[13:0]);

  always_ff @(posedge clk) begin
    year_quot <= year_prod[28:RECIP25_SHIFT];
    year_leap <= (year_sum[1:0] == 2'd0 && !year_div25)
              || (year_sum[3:0] == 4'd0 && year_div25);
  end

  dtcp_range_check u_check (
    .fields    (fields_next),
    .pos_next  (pos_next),
    .header_ok (header_ok_next),
    .leap      (year_leap),
    .ok        (cmd_ok)
  );

  assign result_data = cmd_ok ? {fields_next.second[5:0], fields_next.minute[5:0],
                                 fields_next.hour[4:0],   fields_next.day[4:0],
                                 fields_next.month[3:0],  fields_next.year[13:0]}
                              : '0;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (a_move && a_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (a_move && a_last) begin
      m_tdata <= result_data;
      m_tuser <= cmd_ok;
    end
  end

  // A finished command leaves the parser in its reset state.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    a_move && a_last |=> pos == '0 && header_ok && year_sum == '0 && second_sum == '0)
    else $error("parser state not cleared after final character");

  // A failed command carries all-zero fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("failed command with nonzero fields");

  // A passing command has a month in range and a nonzero day.
  a_ok_ranges: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[17:14] >= 4'd1 && m_tdata[17:14] <= 4'd12
                            && m_tdata[22:18] != 5'd0)
    else $error("passing command with month or day out of range");

  // A result only appears after a final character left the input register.
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(a_move && a_last))
    else $error("result without a final character");

endmodule

// ----- test/datetime_command_parser_tb.sv -----
// Self-checking testbench for datetime_command_parser: directed commands from a
// table, then random date-time commands, checked against a local parser model.
// Depends on dtcp_pkg and the datetime_command_parser RTL.
module datetime_command_parser_tb import dtcp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // One parsed date as the block reports it: valid flag plus the six fields.
  typedef struct packed {
    logic        valid;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } dt_result_t;

  typedef logic [CHAR_W-1:0] char_q_t[$];

  // A directed command. poke_pos, when not negative, replaces one character
  // with a raw byte so that bytes a string cannot hold (zero) can be sent.
  // When typed is set, want is the result read straight off the spec;
  // otherwise the local parser model supplies it.
  typedef struct {
    string             text;
    int                poke_pos;
    logic [CHAR_W-1:0] poke_val;
    bit                typed;
    dt_result_t        want;
  } dir_row_t;

  localparam dt_result_t NO_DATE  = '0;
  localparam dt_result_t MAX_DATE = '{1'b1, 14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59};
  localparam dt_result_t MIN_DATE = '{1'b1, 14'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0};

  localparam int RANDOM_CHARS = 1400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_AFTER   = 30;
  localparam int N_DIR        = 21;

  // Directed commands: extremes, leap rules, every range check, header and
  // length failures, a count that would wrap to 16 without saturation, and
  // raw bytes (zero and all-ones) in digit and header positions.
  dir_row_t dir_tab [N_DIR] = '{
    '{"TA99991231235959", -1, 8'h00, 1'b1, MAX_DATE},
    '{"ta00000101000000", -1, 8'h00, 1'b1, MIN_DATE},
    '{"tA20240229235959", -1, 8'h00, 1'b0, NO_DATE},
    '{"Ta19000229000000", -1, 8'h00, 1'b1, NO_DATE},
    '{"TA20000229120000", -1, 8'h00, 1'b0, NO_DATE},
    '{"TA20230431000000", -1, 8'h00, 1'b1, NO_DATE},
    '{"TA20241301000000", -1, 8'h00, 1'b1, NO_DATE},
    '{"TA20240001000000", -1, 8'h00, 1'b1, NO_DATE},
    '{"TA20240100000000", -1, 8'h00, 1'b1, NO_DATE},
    '{"TA20240101240000", -1, 8'h00, 1'b1, NO_DATE},
    '{"TA20240101006000", -1, 8'h00, 1'b1, NO_DATE},
    '{"TA20240101000060", -1, 8'h00, 1'b1, NO_DATE},
    '{"XA20240101000000", -1, 8'h00, 1'b1, NO_DATE},
    '{"TB20240101000000", -1, 8'h00, 1'b1, NO_DATE},
    '{"TA2024010100000", -1, 8'h00, 1'b1, NO_DATE},
    '{"TA202401010000000", -1, 8'h00, 1'b1, NO_DATE},
    '{"T", -1, 8'h00, 1'b1, NO_DATE},
    '{"TA20240229123000TA20240229123000TA20240229123000", -1, 8'h00, 1'b1, NO_DATE},
    '{"TA20240101000050", 15, 8'h00, 1'b0, NO_DATE},
    '{"TA20240101000000", 0, 8'hFF, 1'b1, NO_DATE},
    '{"TA20240101000000", 2, 8'h00, 1'b1, NO_DATE}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [CHAR_W-1:0]  s_tdata = '0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;

  // Parser model state: character count and the running digit sums.
  logic [4:0]         char_cnt;
  logic               hdr_ok;
  logic signed [19:0] yr_acc;
  logic signed [12:0] mo_acc, dy_acc, hr_acc, mi_acc, se_acc;

  dt_result_t pending_dates[$];
  int         n_err = 0;
  int         results_seen = 0;
  int         chars_sent = 0;
  int         cycles = 0;
  bit         quiet = 1'b0;

  datetime_command_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic bit is_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(input int m, input int y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic void clear_parse();
    char_cnt = '0;
    hdr_ok   = 1'b1;
    yr_acc   = '0;
    mo_acc   = '0;
    dy_acc   = '0;
    hr_acc   = '0;
    mi_acc   = '0;
    se_acc   = '0;
  endfunction

  // Folds one accepted character into the model. On the final character it
  // judges the whole command and hands back the date the block must report.
  function automatic void fold_char(input logic [CHAR_W-1:0] c, input logic fin,
                                    output logic produced, output dt_result_t res);
    int   v;
    logic ok;
    v = int'(c) - DIGIT_ZERO;
    produced = 1'b0;
    res = NO_DATE;
    if (char_cnt == 0) begin
      if (c != CHAR_T_UP && c != CHAR_T_LO) hdr_ok = 1'b0;
    end else if (char_cnt == 1) begin
      if (c != CHAR_A_UP && c != CHAR_A_LO) hdr_ok = 1'b0;
    end else if (char_cnt <= 5) begin
      yr_acc = yr_acc * 10 + v;
    end else if (char_cnt <= 7) begin
      mo_acc = mo_acc * 10 + v;
    end else if (char_cnt <= 9) begin
      dy_acc = dy_acc * 10 + v;
    end else if (char_cnt <= 11) begin
      hr_acc = hr_acc * 10 + v;
    end else if (char_cnt <= 13) begin
      mi_acc = mi_acc * 10 + v;
    end else if (char_cnt <= 15) begin
      se_acc = se_acc * 10 + v;
    end
    // The count sticks at its maximum so an overlong command never reads as 16.
    if (char_cnt < POS_MAX) char_cnt++;
    if (fin) begin
      ok = (char_cnt == CMD_LEN) && hdr_ok
        && yr_acc >= 0 && yr_acc <= YEAR_MAX
        && mo_acc >= 1 && mo_acc <= MONTH_MAX
        && dy_acc >= 1 && dy_acc <= month_length(mo_acc, yr_acc)
        && hr_acc >= 0 && hr_acc <= HOUR_MAX
        && mi_acc >= 0 && mi_acc <= MINSEC_MAX
        && se_acc >= 0 && se_acc <= MINSEC_MAX;
      if (ok) begin
        res.valid  = 1'b1;
        res.year   = yr_acc[13:0];
        res.month  = mo_acc[3:0];
        res.day    = dy_acc[4:0];
        res.hour   = hr_acc[4:0];
        res.minute = mi_acc[5:0];
        res.second = se_acc[5:0];
      end
      produced = 1'b1;
      clear_parse();
    end
  endfunction

  // Idle length between requests: mostly none or short, now and then long.
  // While quiet is set both sides run without any gaps.
  function automatic int idle_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_digits(inout char_q_t q, input int val, input int n);
    int div;
    div = 1;
    repeat (n - 1) div *= 10;
    repeat (n) begin
      q.push_back(CHAR_W'(DIGIT_ZERO + (val / div) % 10));
      div /= 10;
    end
  endfunction

  // Builds a random command. Most are well formed with random dates that
  // lean towards February, leap-year boundaries and the edges of each range;
  // some are damaged in one place and a few are plain byte noise.
  function automatic char_q_t random_command();
    char_q_t q;
    int      kind, yr, mo, dy, hr, mi, se, len, pos;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 50) : $urandom_range(1, 18);
      repeat (len) q.push_back(CHAR_W'($urandom_range(0, 255)));
      return q;
    end
    q.push_back($urandom_range(0, 1) ? CHAR_T_UP : CHAR_T_LO);
    q.push_back($urandom_range(0, 1) ? CHAR_A_UP : CHAR_A_LO);
    case ($urandom_range(0, 3))
      0:       yr = $urandom_range(0, YEAR_MAX);
      1:       yr = 4 * $urandom_range(0, 2499);
      2:       yr = 100 * $urandom_range(0, 99);
      default: yr = $urandom_range(0, 1) ? 0 : YEAR_MAX;
    endcase
    case ($urandom_range(0, 9))
      0:       mo = $urandom_range(0, 19);
      1, 2, 3: mo = 2;
      default: mo = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 9))
      0:       dy = $urandom_range(0, 39);
      1, 2, 3: dy = $urandom_range(28, 31);
      default: dy = $urandom_range(1, 28);
    endcase
    hr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 39) : $urandom_range(0, 23);
    mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    se = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    push_digits(q, yr, 4);
    push_digits(q, mo, 2);
    push_digits(q, dy, 2);
    push_digits(q, hr, 2);
    push_digits(q, mi, 2);
    push_digits(q, se, 2);
    if (kind < 30) begin
      pos = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 2))
        0:       q[pos] = CHAR_W'($urandom_range(0, 255));
        1:       q.delete(pos);
        default: q.insert(pos, CHAR_W'($urandom_range(0, 255)));
      endcase
    end
    return q;
  endfunction

  // Sends one command, one request per character, with s_tlast on the final
  // one. Entered and left at a falling edge. s_tvalid stays high across
  // back-to-back requests and is only lowered for a gap.
  task automatic send_cmd(input char_q_t cmd, input bit typed, input dt_result_t want);
    int         gap;
    logic       produced;
    dt_result_t res;
    for (int i = 0; i < cmd.size(); i++) begin
      gap = idle_gap();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= cmd[i];
      s_tlast  <= (i == cmd.size() - 1);
      do @(posedge clk); while (!s_tready);
      chars_sent++;
      fold_char(cmd[i], i == cmd.size() - 1, produced, res);
      if (produced) pending_dates.push_back(typed ? want : res);
      @(negedge clk);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endtask

  // Every result taken from the master side is matched against the oldest
  // date still waiting. m_tdata holds year, month, day, hour, minute and
  // second from the low bits up; m_tuser is the valid flag.
  always @(posedge clk) begin : result_check
    dt_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_dates.size() == 0) begin
        $error("result with no command waiting: tuser %0d tdata %h", m_tuser, m_tdata);
        n_err++;
      end else begin
        want = pending_dates.pop_front();
        check_field("valid_res", want.valid, m_tuser);
        check_field("year", want.year, m_tdata[13:0]);
        check_field("month", want.month, m_tdata[17:14]);
        check_field("day", want.day, m_tdata[22:18]);
        check_field("hour", want.hour, m_tdata[27:23]);
        check_field("minute", want.minute, m_tdata[33:28]);
        check_field("second", want.second, m_tdata[39:34]);
      end
    end
  end

  // Receiver side: ready in bursts with random gaps. Once, after a few dozen
  // results, it holds off for a long stretch while the sender keeps offering
  // characters, so the result register and the input register both fill and
  // the block has to stall its input.
  initial begin : receiver
    int  gap;
    bit  held;
    held = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    char_q_t cmd;
    clear_parse();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table first.
    for (int r = 0; r < N_DIR; r++) begin
      cmd.delete();
      for (int i = 0; i < dir_tab[r].text.len(); i++)
        cmd.push_back(i == dir_tab[r].poke_pos ? dir_tab[r].poke_val : dir_tab[r].text[i]);
      send_cmd(cmd, dir_tab[r].typed, dir_tab[r].want);
    end

    // Random commands, with occasional stretches where neither side idles.
    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      quiet = ($urandom_range(0, 7) == 0);
      send_cmd(random_command(), 1'b0, NO_DATE);
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    // Drain: wait for every expected date, then a few cycles more so that a
    // stray extra result would still be caught.
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
